// ===== rtl/prs_pkg.sv =====
package prs_pkg;

	// Default field widths
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int RTT_WIDTH_DEF   = 24;

	// Loss is a percentage: quotient of a value up to 100 * sent by sent
	localparam int PERCENT_SCALE = 100;
	localparam int LOSS_WIDTH    = $clog2(PERCENT_SCALE + 1);
	localparam int LOSS_LAST     = LOSS_WIDTH - 1;

	// Event kinds
	localparam logic [1:0] ACT_PROBE  = 2'd0;
	localparam logic [1:0] ACT_REPLY  = 2'd1;
	localparam logic [1:0] ACT_SAMPLE = 2'd2;

	// Reply status codes
	localparam logic [1:0] ST_FIRST   = 2'd0;
	localparam logic [1:0] ST_DUP     = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== rtl/prs_divider.sv =====
module prs_divider import prs_pkg::*; #(
	parameter int DW   = 57,
	parameter int QW   = 25,
	parameter int CNTW = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DW-1:0]   dividend,
	input  logic [DW-1:0]   divisor_sh,  // divisor already shifted to the top quotient bit
	input  logic [CNTW-1:0] last_step,   // index of the top quotient bit
	output div_sts_t        sts,
	output logic [QW-1:0]   quotient
);

	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   dsh_q;
	logic [QW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic            fit;

	// One restoring step: compare and subtract the shifted divisor
	assign fit = (rem_q >= dsh_q);

	// Control: run for last_step + 1 steps, then pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= last_step;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then shift out one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= divisor_sh;
			quo_q <= '0;
		end else if (run_q) begin
			if (fit)
				rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QW-2:0], fit};
		end
	end

	assign sts.busy = run_q;
	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/probe_reply_statistics.sv =====
// Sequence: an accepted item is applied to the counters, the unique count is formed,
//   and the one shared divider computes the loss percent, then the mean RTT; the
//   result word is loaded once the output register is free. A division is skipped,
//   leaving a zero, when sent is zero or unique is not below sent (loss), or when no
//   samples exist (mean).
// Intake: a new item is taken only in idle, once the last one is done; it may be
//   taken while the last result still waits on the output.
// Reset: arst_n zeroes the event counters, min, max and sum; no output is valid.
module probe_reply_statistics import prs_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int RTT_WIDTH   = RTT_WIDTH_DEF,
	localparam int IN_W  = ((RTT_WIDTH + 7) / 8) * 8,
	localparam int OUT_BITS = 6 * COUNT_WIDTH + 3 * RTT_WIDTH + LOSS_WIDTH,
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // rtt_value
	input  logic [3:0]       s_tuser,   // action, reply_status
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // sent_count, received_count, duplicate_count,
	                                    // unmatched_count, unique_count, loss_percent,
	                                    // rtt_minimum, rtt_mean, rtt_maximum, sample_count
);

	localparam int CW   = COUNT_WIDTH;
	localparam int RW   = RTT_WIDTH;
	localparam int SW   = (CW + RW > 64) ? 64 : CW + RW;
	localparam int DW   = CW + RW + 1;
	localparam int QW   = RW + 1;
	localparam int CNTW = $clog2(RW + 1);
	localparam int LOSS_LO = 5 * CW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UPD  = 3'd1;
	localparam logic [2:0] S_UNIQ = 3'd2;
	localparam logic [2:0] S_LDL  = 3'd3;
	localparam logic [2:0] S_WL   = 3'd4;
	localparam logic [2:0] S_LDM  = 3'd5;
	localparam logic [2:0] S_WM   = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0]      state_q;
	logic [1:0]      action_q;
	logic [1:0]      status_q;
	logic [RW-1:0]   rtt_q;

	logic [CW-1:0]   sent_q;
	logic [CW-1:0]   reply_q;
	logic [CW-1:0]   dup_q;
	logic [CW-1:0]   unm_q;
	logic [CW-1:0]   sample_q;
	logic [RW-1:0]   rtt_low_q;
	logic [RW-1:0]   rtt_high_q;
	logic [SW-1:0]   sum_q;
	logic [CW-1:0]   unique_q;
	logic [LOSS_WIDTH-1:0] loss_q;
	logic [RW-1:0]   mean_q;
	logic            m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic [CW:0]     other;
	logic [SW:0]     sum_ext;
	logic [CW-1:0]   diff;
	logic [DW-1:0]   diff_ext;
	logic            div_start;
	logic [DW-1:0]   div_dividend;
	logic [DW-1:0]   div_divisor;
	logic [CNTW-1:0] div_last;
	div_sts_t        div_sts;
	logic [QW-1:0]   div_quo;
	logic            out_free;

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	assign other    = {1'b0, dup_q} + {1'b0, unm_q};
	assign sum_ext  = {1'b0, sum_q} + (SW + 1)'(rtt_q);
	assign diff     = sent_q - unique_q;
	assign diff_ext = DW'(diff);

	// Set up the shared divider for loss or for mean
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		div_last     = '0;
		if (state_q == S_LDL && sent_q != '0 && unique_q < sent_q) begin
			div_start    = 1'b1;
			div_dividend = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
			div_divisor  = DW'(sent_q) << LOSS_LAST;
			div_last     = CNTW'(LOSS_LAST);
		end else if (state_q == S_LDM && sample_q != '0) begin
			div_start    = 1'b1;
			div_dividend = DW'(sum_q);
			div_divisor  = DW'(sample_q) << RW;
			div_last     = CNTW'(RW);
		end
	end

	prs_divider #(
		.DW   (DW),
		.QW   (QW),
		.CNTW (CNTW)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.dividend   (div_dividend),
		.divisor_sh (div_divisor),
		.last_step  (div_last),
		.sts        (div_sts),
		.quotient   (div_quo)
	);

	// Sequencer and statistics registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sent_q     <= '0;
			reply_q    <= '0;
			dup_q      <= '0;
			unm_q      <= '0;
			sample_q   <= '0;
			rtt_low_q  <= '0;
			rtt_high_q <= '0;
			sum_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// Raise the result when it is loaded, drop it once taken
			if (state_q == S_DONE && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid)
						state_q <= S_UPD;
				end
				S_UPD: begin
					// Apply the event, counters saturate
					unique case (action_q)
						ACT_PROBE: begin
							if (sent_q != '1)
								sent_q <= sent_q + 1'b1;
						end
						ACT_REPLY: begin
							if (reply_q != '1)
								reply_q <= reply_q + 1'b1;
							if (status_q == ST_DUP && dup_q != '1)
								dup_q <= dup_q + 1'b1;
							if (status_q == ST_UNKNOWN && unm_q != '1)
								unm_q <= unm_q + 1'b1;
						end
						ACT_SAMPLE: begin
							if (sample_q == '0 || rtt_q < rtt_low_q)
								rtt_low_q <= rtt_q;
							if (sample_q == '0 || rtt_q > rtt_high_q)
								rtt_high_q <= rtt_q;
							if (sample_q != '1)
								sample_q <= sample_q + 1'b1;
							sum_q <= sum_ext[SW] ? '1 : sum_ext[SW-1:0];
						end
						default: ;
					endcase
					state_q <= S_UNIQ;
				end
				S_UNIQ: state_q <= S_LDL;
				S_LDL: state_q <= div_start ? S_WL : S_LDM;
				S_WL: begin
					if (div_sts.done)
						state_q <= S_LDM;
				end
				S_LDM: state_q <= div_start ? S_WM : S_DONE;
				S_WM: begin
					if (div_sts.done)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the item, work values and the result word
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			action_q <= s_tuser[1:0];
			status_q <= s_tuser[3:2];
			rtt_q    <= s_tdata[RW-1:0];
		end
		if (state_q == S_UNIQ)
			unique_q <= (CW + 1)'(reply_q) > other ? reply_q - other[CW-1:0] : '0;
		if (state_q == S_LDL && !div_start)
			loss_q <= '0;
		if (state_q == S_WL && div_sts.done)
			loss_q <= div_quo[LOSS_WIDTH-1:0];
		if (state_q == S_LDM && !div_start)
			mean_q <= '0;
		if (state_q == S_WM && div_sts.done)
			mean_q <= div_quo[RW] ? '1 : div_quo[RW-1:0];
		if (state_q == S_DONE && out_free)
			m_tdata_q <= OUT_W'({sample_q, rtt_high_q, mean_q, rtt_low_q, loss_q,
				unique_q, unm_q, dup_q, reply_q, sent_q});
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Loss never exceeds one hundred percent
	a_loss_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[LOSS_LO +: LOSS_WIDTH] <= LOSS_WIDTH'(PERCENT_SCALE))
		else $error("loss percent above 100");

	// Minimum stays at or below maximum once samples exist
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		sample_q != '0 |-> rtt_low_q <= rtt_high_q)
		else $error("rtt minimum above maximum");

	// Unique replies never exceed received replies
	a_unique: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LDL |-> unique_q <= reply_q)
		else $error("unique count above received count");

	// Divider runs only while the sequencer waits on it
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.busy |-> (state_q == S_WL || state_q == S_WM))
		else $error("divider busy outside a wait state");

	// A finished division follows a run of the divider
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> $past(div_sts.busy))
		else $error("divider done without a run");

endmodule
